>>> design/fsht_pkg.sv
// Shared types, widths and register codes for the fuzzy set point to heat time core.
// No dependencies; every other design file except fsht_chan_if imports this package.
`default_nettype none

package fsht_pkg;

	localparam int SP_W          = 11;
	localparam int MU_W          = 13;
	localparam int W_W           = 12;
	localparam int CYC_W         = 16;
	localparam int HEAT_W        = 12;
	localparam int NSETS         = 4;
	localparam int FRAC_BITS_DEF = 4;
	localparam int ONE_Q12       = 4096;
	localparam int SUM_W         = 15;
	localparam int PROD_W        = W_W + MU_W;
	localparam int DVD_W         = 27;
	localparam int QBITS_STAGE   = 2;
	localparam int DIV_STAGES    = HEAT_W / QBITS_STAGE;
	localparam int REG_ADDR_W    = 3;

	// reciprocal of 5 in 0.18, exact for 16 bit dividends
	localparam logic [15:0] RECIP5 = 16'hCCCD;

	localparam int SET_NEG   = 0;
	localparam int SET_SMALL = 1;
	localparam int SET_MED   = 2;
	localparam int SET_LARGE = 3;

	typedef enum logic [REG_ADDR_W-1:0] {
		REG_W_NEG   = 3'd0,
		REG_W_SMALL = 3'd1,
		REG_W_MED   = 3'd2,
		REG_W_LARGE = 3'd3,
		REG_CYCLE   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MK_ZERO,
		MK_FULL,
		MK_SLOPE
	} mkind_t;

	typedef logic [MU_W-1:0] mu_t;
	typedef mu_t [NSETS-1:0] mu_vec_t;
	typedef logic [W_W-1:0] weight_t;
	typedef weight_t [NSETS-1:0] weight_vec_t;

	typedef struct packed {
		mkind_t      kind;
		logic        wide;
		logic [15:0] xq;
	} mterm_t;

	typedef struct packed {
		mu_vec_t             mu;
		logic [SUM_W-1:0]    divisor;
		logic [DVD_W-1:0]    rem;
		logic [HEAT_W-1:0]   quo;
	} div_item_t;

	typedef struct packed {
		logic signed [SP_W-1:0] setpoint;
	} in_item_t;

	typedef struct packed {
		mu_t               mu_negative;
		mu_t               mu_small;
		mu_t               mu_medium;
		mu_t               mu_large;
		logic [HEAT_W-1:0] heat_ms;
		logic [CYC_W-1:0]  off_ms;
		logic              no_rule;
	} out_item_t;

	typedef struct packed {
		logic [REG_ADDR_W-1:0] addr;
		logic [CYC_W-1:0]      wdata;
	} cfg_req_t;

endpackage

`default_nettype wire

>>> design/fsht_chan_if.sv
// Valid/ready channel carrying one request of payload type T.
// Used for the set point, result and register write channels; no dependencies.
`default_nettype none

interface fsht_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/fuzzy_setpoint_to_heat_time_core.sv
// Top level: register file, membership, weighted sum and divider pipeline, output stage.
// Depends on fsht_pkg, fsht_chan_if, fsht_member, fsht_wsum and fsht_div.
//
// Each set point request yields one result: four Q1.12 memberships, the
// membership-weighted heat time rounded to nearest, the off time (cycle
// minus heat, floored at zero) and a flag when no set fires. The pipeline
// is 12 register stages deep (3 membership, 2 weighted sum, 6 divider at
// two quotient bits each, 1 output) and takes a new request every cycle
// unless the result stalls; a stall holds only the full stages behind it.
// Register writes are taken at once; the user, not the block, must keep them to idle.
`default_nettype none

module fuzzy_setpoint_to_heat_time_core import fsht_pkg::*; #(
	parameter int SETPOINT_FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	fsht_chan_if.sink   item,
	fsht_chan_if.source result,
	fsht_chan_if.sink   cfg
);

	weight_vec_t       weight_q;
	logic [CYC_W-1:0]  cycle_q;

	logic              mem_valid, mem_ready;
	mu_vec_t           mem_mu;
	logic              ws_valid, ws_ready;
	div_item_t         ws_item;
	logic              dv_valid, dv_ready;
	div_item_t         dv_item;

	out_item_t         res_s;
	logic              v_out_s;
	logic              nr;
	logic [HEAT_W-1:0] heat;
	logic [CYC_W-1:0]  heat_ext;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q[SET_NEG]   <= W_W'(0);
			weight_q[SET_SMALL] <= W_W'(200);
			weight_q[SET_MED]   <= W_W'(500);
			weight_q[SET_LARGE] <= W_W'(1000);
			cycle_q             <= CYC_W'(1000);
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.data.addr))
				REG_W_NEG:   weight_q[SET_NEG]   <= cfg.data.wdata[W_W-1:0];
				REG_W_SMALL: weight_q[SET_SMALL] <= cfg.data.wdata[W_W-1:0];
				REG_W_MED:   weight_q[SET_MED]   <= cfg.data.wdata[W_W-1:0];
				REG_W_LARGE: weight_q[SET_LARGE] <= cfg.data.wdata[W_W-1:0];
				REG_CYCLE:   cycle_q             <= cfg.data.wdata;
				default:     ;
			endcase
		end
	end

	fsht_member #(
		.FRAC_BITS (SETPOINT_FRAC_BITS)
	) u_member (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.setpoint  (item.data.setpoint),
		.out_valid (mem_valid),
		.out_ready (mem_ready),
		.mu        (mem_mu)
	);

	fsht_wsum u_wsum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mem_valid),
		.in_ready  (mem_ready),
		.mu        (mem_mu),
		.weights   (weight_q),
		.out_valid (ws_valid),
		.out_ready (ws_ready),
		.item      (ws_item)
	);

	fsht_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ws_valid),
		.in_ready  (ws_ready),
		.in_item   (ws_item),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_item  (dv_item)
	);

	assign nr       = (dv_item.divisor == '0);
	assign heat     = nr ? '0 : dv_item.quo;
	assign heat_ext = CYC_W'(heat);
	assign dv_ready = !v_out_s || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_s <= 1'b0;
		end else if (dv_ready) begin
			v_out_s <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready && dv_valid) begin
			res_s.mu_negative <= dv_item.mu[SET_NEG];
			res_s.mu_small    <= dv_item.mu[SET_SMALL];
			res_s.mu_medium   <= dv_item.mu[SET_MED];
			res_s.mu_large    <= dv_item.mu[SET_LARGE];
			res_s.heat_ms     <= heat;
			res_s.off_ms      <= (cycle_q > heat_ext) ? (cycle_q - heat_ext) : '0;
			res_s.no_rule     <= nr;
		end
	end

	assign result.valid = v_out_s;
	assign result.data  = res_s;

endmodule

`default_nettype wire

>>> design/fsht_member.sv
// Membership stages s1..s3: region select, slope scaling and divide by 5 or 10.
// Depends on fsht_pkg.
`default_nettype none

module fsht_member import fsht_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [SP_W-1:0] setpoint,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output mu_vec_t                     mu
);

	localparam int S  = 1 << FRAC_BITS;
	localparam int XW = 16;
	localparam int SW = 28;
	localparam logic signed [XW-1:0] P5  = XW'(5 * S);
	localparam logic signed [XW-1:0] P10 = XW'(10 * S);
	localparam logic signed [XW-1:0] P15 = XW'(15 * S);
	localparam logic signed [XW-1:0] P25 = XW'(25 * S);
	localparam logic [XW-1:0] DEN5   = XW'(5 * S);
	localparam logic [XW-1:0] DEN10  = XW'(10 * S);
	localparam logic [XW-1:0] HALF5  = XW'((5 * S) / 2);
	localparam logic [XW-1:0] HALF10 = XW'(5 * S);

	function automatic mterm_t classify(input logic signed [XW-1:0] num, input logic wide);
		mterm_t          t;
		logic [XW-1:0]   den;
		logic [SW-1:0]   scaled;
		t      = '0;
		den    = wide ? DEN10 : DEN5;
		scaled = (SW'($unsigned(num)) << 12) + SW'(wide ? HALF10 : HALF5);
		t.wide = wide;
		t.kind = MK_ZERO;
		if (num <= 0) begin
			t.kind = MK_ZERO;
		end else if ($unsigned(num) >= den) begin
			t.kind = MK_FULL;
		end else begin
			t.kind = MK_SLOPE;
			t.xq   = 16'(scaled >> FRAC_BITS);
		end
		return t;
	endfunction

	logic signed [XW-1:0] x;
	mterm_t [NSETS-1:0]   term_d;

	mterm_t [NSETS-1:0]   term_s1;
	logic                 v_s1;
	mkind_t               kind_s2 [NSETS];
	logic                 wide_s2 [NSETS];
	logic [31:0]          prod_s2 [NSETS];
	logic                 v_s2;
	mu_vec_t              mu_s3;
	logic                 v_s3;
	logic                 rdy1, rdy2, rdy3;

	assign x = XW'(setpoint);

	always_comb begin
		term_d = '0;
		// negative shoulder
		if (x <= 0) begin
			term_d[SET_NEG].kind = MK_FULL;
		end else begin
			term_d[SET_NEG] = classify(P5 - x, 1'b0);
		end
		// small triangle
		if (x < 0 || x > P10) begin
			term_d[SET_SMALL].kind = MK_ZERO;
		end else if (x <= P5) begin
			term_d[SET_SMALL] = classify(x, 1'b0);
		end else begin
			term_d[SET_SMALL] = classify(P10 - x, 1'b0);
		end
		// medium triangle
		if (x < P5 || x > P25) begin
			term_d[SET_MED].kind = MK_ZERO;
		end else if (x <= P15) begin
			term_d[SET_MED] = classify(x - P5, 1'b1);
		end else begin
			term_d[SET_MED] = classify(P25 - x, 1'b1);
		end
		// large shoulder
		if (x < P25) begin
			term_d[SET_LARGE].kind = MK_ZERO;
		end else begin
			term_d[SET_LARGE] = classify(x - P25, 1'b0);
		end
	end

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) term_s1 <= term_d;
		if (rdy2 && v_s1) begin
			for (int i = 0; i < NSETS; i++) begin
				kind_s2[i] <= term_s1[i].kind;
				wide_s2[i] <= term_s1[i].wide;
				prod_s2[i] <= 32'(term_s1[i].xq) * 32'(RECIP5);
			end
		end
		if (rdy3 && v_s2) begin
			for (int i = 0; i < NSETS; i++) begin
				case (kind_s2[i])
					MK_FULL:  mu_s3[i] <= MU_W'(ONE_Q12);
					MK_SLOPE: mu_s3[i] <= wide_s2[i] ? MU_W'(prod_s2[i] >> 19)
					                                 : MU_W'(prod_s2[i] >> 18);
					default:  mu_s3[i] <= '0;
				endcase
			end
		end
	end

	assign out_valid = v_s3;
	assign mu        = mu_s3;

endmodule

`default_nettype wire

>>> design/fsht_wsum.sv
// Weighted sum stages s4..s5: rule products, membership sum and rounded dividend.
// Depends on fsht_pkg.
`default_nettype none

module fsht_wsum import fsht_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire mu_vec_t     mu,
	input  wire weight_vec_t weights,
	output logic             out_valid,
	input  wire logic        out_ready,
	output div_item_t        item
);

	logic [PROD_W-1:0] prod_s4 [NSETS];
	mu_vec_t           mu_s4;
	logic [SUM_W-1:0]  sum_s4;
	logic              v_s4;
	div_item_t         item_s5;
	logic              v_s5;
	logic              rdy4, rdy5;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign in_ready = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy4) v_s4 <= in_valid;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && in_valid) begin
			for (int i = 0; i < NSETS; i++) begin
				prod_s4[i] <= PROD_W'(weights[i]) * PROD_W'(mu[i]);
			end
			mu_s4  <= mu;
			sum_s4 <= SUM_W'(mu[SET_NEG]) + SUM_W'(mu[SET_SMALL])
			        + SUM_W'(mu[SET_MED]) + SUM_W'(mu[SET_LARGE]);
		end
		if (rdy5 && v_s4) begin
			item_s5.mu      <= mu_s4;
			item_s5.divisor <= sum_s4;
			item_s5.quo     <= '0;
			item_s5.rem     <= DVD_W'(prod_s4[SET_NEG]) + DVD_W'(prod_s4[SET_SMALL])
			                 + DVD_W'(prod_s4[SET_MED]) + DVD_W'(prod_s4[SET_LARGE])
			                 + DVD_W'(sum_s4 >> 1);
		end
	end

	assign out_valid = v_s5;
	assign item      = item_s5;

endmodule

`default_nettype wire

>>> design/fsht_div.sv
// Pipelined restoring divider, QBITS_STAGE quotient bits per stage, MSB first.
// Depends on fsht_pkg.
`default_nettype none

module fsht_div import fsht_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire div_item_t in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output div_item_t      out_item
);

	function automatic div_item_t div_step(input div_item_t d, input int top_bit);
		div_item_t        r;
		logic [DVD_W-1:0] sub;
		int               b;
		r = d;
		for (int j = 0; j < QBITS_STAGE; j++) begin
			b   = top_bit - j;
			sub = DVD_W'(r.divisor) << b;
			if (r.rem >= sub) begin
				r.rem    = r.rem - sub;
				r.quo[b] = 1'b1;
			end
		end
		return r;
	endfunction

	div_item_t item_s [DIV_STAGES];
	logic      v_s    [DIV_STAGES];
	logic      rdy    [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		div_item_t src;
		logic      src_v;
		if (k == 0) begin : g_first
			assign src   = in_item;
			assign src_v = in_valid;
		end else begin : g_next
			assign src   = item_s[k-1];
			assign src_v = v_s[k-1];
		end

		if (k == DIV_STAGES - 1) begin : g_last
			assign rdy[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign rdy[k] = !v_s[k] || rdy[k+1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v) item_s[k] <= div_step(src, HEAT_W - 1 - k * QBITS_STAGE);
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[DIV_STAGES-1];
	assign out_item  = item_s[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> design/fsht_checker.sv
// Port-level assertions for the core and the bind that attaches them.
// Depends on fsht_pkg and fuzzy_setpoint_to_heat_time_core.
`default_nettype none

module fsht_checker import fsht_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	logic all_zero;

	assign all_zero = (out_data.mu_negative == '0) && (out_data.mu_small == '0)
	               && (out_data.mu_medium == '0) && (out_data.mu_large == '0);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_no_rule_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.no_rule == all_zero))
		else $error("no_rule disagrees with memberships");

	a_no_rule_heat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_rule |-> out_data.heat_ms == '0)
		else $error("heat time not zero with no rule");

	a_mu_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.mu_negative <= MU_W'(ONE_Q12)
		           && out_data.mu_small <= MU_W'(ONE_Q12)
		           && out_data.mu_medium <= MU_W'(ONE_Q12)
		           && out_data.mu_large <= MU_W'(ONE_Q12))
		else $error("membership above one");

endmodule

bind fuzzy_setpoint_to_heat_time_core fsht_checker u_fsht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

`default_nettype wire

>>> tb/fuzzy_setpoint_to_heat_time_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fuzzy_setpoint_to_heat_time_core: membership, heat and off times.
// Depends on fsht_pkg, fsht_chan_if and the core; predicts each result in SystemVerilog.

module fuzzy_setpoint_to_heat_time_core_tb;
	import fsht_pkg::*;

	localparam int PIPE_LATENCY = 12;
	localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
	localparam int IDLE_LIMIT = 5000;
	localparam int PRINT_CAP = 40;

	typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC} rx_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fsht_chan_if #(.T(in_item_t))  sp_req ();
	fsht_chan_if #(.T(out_item_t)) heat_rsp ();
	fsht_chan_if #(.T(cfg_req_t))  reg_wr ();

	fuzzy_setpoint_to_heat_time_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (sp_req),
		.result (heat_rsp),
		.cfg    (reg_wr)
	);

	always #5 clk = ~clk;

	// predictor copy of the register file
	weight_t          rule_ms [NSETS];
	logic [CYC_W-1:0] cycle_len;

	out_item_t pending_heat_results [$];
	int        fail_count = 0;
	int        idle_cycles = 0;
	int        hold_off_left = 0;
	int        burst_left = 0;
	bit        gaps_on = 1'b0;
	rx_style_t rx_style = RX_FREE;
	int        rx_phase_left = 0;
	int        rx_tick = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	function automatic longint q12_ramp(input longint num, input longint den);
		if (den <= 0 || num <= 0)
			return 0;
		if (num >= den)
			return ONE_Q12;
		return (num * ONE_Q12 + den / 2) / den;
	endfunction

	function automatic out_item_t predict_heat_time(input logic signed [SP_W-1:0] sp);
		longint    x;
		longint    s;
		longint    mu [NSETS];
		longint    sum;
		longint    acc;
		longint    heat;
		out_item_t r;
		x = sp;
		s = longint'(1) << FRAC_BITS_DEF;
		mu[SET_NEG] = (x <= 0) ? ONE_Q12 : q12_ramp(5 * s - x, 5 * s);
		if (x < 0 || x > 10 * s)
			mu[SET_SMALL] = 0;
		else if (x <= 5 * s)
			mu[SET_SMALL] = q12_ramp(x, 5 * s);
		else
			mu[SET_SMALL] = q12_ramp(10 * s - x, 5 * s);
		if (x < 5 * s || x > 25 * s)
			mu[SET_MED] = 0;
		else if (x <= 15 * s)
			mu[SET_MED] = q12_ramp(x - 5 * s, 10 * s);
		else
			mu[SET_MED] = q12_ramp(25 * s - x, 10 * s);
		mu[SET_LARGE] = (x < 25 * s) ? 0 : q12_ramp(x - 25 * s, 5 * s);
		sum = 0;
		acc = 0;
		for (int i = 0; i < NSETS; i++) begin
			sum += mu[i];
			acc += longint'(rule_ms[i]) * mu[i];
		end
		if (sum == 0) begin
			heat = 0;
		end else begin
			heat = (acc + sum / 2) / sum;
			if (heat > (1 << HEAT_W) - 1)
				heat = (1 << HEAT_W) - 1;
		end
		r.mu_negative = MU_W'(mu[SET_NEG]);
		r.mu_small    = MU_W'(mu[SET_SMALL]);
		r.mu_medium   = MU_W'(mu[SET_MED]);
		r.mu_large    = MU_W'(mu[SET_LARGE]);
		r.heat_ms     = HEAT_W'(heat);
		r.off_ms      = (longint'(cycle_len) > heat) ? CYC_W'(longint'(cycle_len) - heat) : '0;
		r.no_rule     = (sum == 0);
		return r;
	endfunction

	task automatic apply_reg_write(input cfg_req_t w);
		case (w.addr)
			REG_W_NEG:   rule_ms[SET_NEG]   = w.wdata[W_W-1:0];
			REG_W_SMALL: rule_ms[SET_SMALL] = w.wdata[W_W-1:0];
			REG_W_MED:   rule_ms[SET_MED]   = w.wdata[W_W-1:0];
			REG_W_LARGE: rule_ms[SET_LARGE] = w.wdata[W_W-1:0];
			REG_CYCLE:   cycle_len = w.wdata;
			default: ;
		endcase
	endtask

	task automatic write_reg(input logic [REG_ADDR_W-1:0] addr, input logic [CYC_W-1:0] value);
		cfg_req_t w;
		w.addr = addr;
		w.wdata = value;
		@(negedge clk);
		reg_wr.valid = 1'b1;
		reg_wr.data = w;
		do @(posedge clk); while (!reg_wr.ready);
		apply_reg_write(w);
		@(negedge clk);
		reg_wr.valid = 1'b0;
	endtask

	task automatic program_registers(input logic [CYC_W-1:0] w_neg, input logic [CYC_W-1:0] w_small,
			input logic [CYC_W-1:0] w_med, input logic [CYC_W-1:0] w_large,
			input logic [CYC_W-1:0] cyc);
		write_reg(REG_W_NEG, w_neg);
		write_reg(REG_W_SMALL, w_small);
		write_reg(REG_W_MED, w_med);
		write_reg(REG_W_LARGE, w_large);
		write_reg(REG_CYCLE, cyc);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		sp_req.valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// registers only change once the pipeline is empty
	task automatic wait_drained();
		pause_sender(1);
		while (pending_heat_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_setpoint(input logic signed [SP_W-1:0] sp);
		in_item_t it;
		if (gaps_on && burst_left == 0) begin
			pause_sender($urandom_range(1, 6));
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		it.setpoint = sp;
		@(negedge clk);
		sp_req.valid = 1'b1;
		sp_req.data = it;
		do @(posedge clk); while (!sp_req.ready);
		pending_heat_results.push_back(predict_heat_time(sp));
	endtask

	function automatic logic signed [SP_W-1:0] random_setpoint();
		int v;
		int corners [6] = '{0, 80, 160, 240, 400, 480};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 600)) - 40;
			6, 7:             v = int'($urandom_range(0, 1600)) - 800;
			8:                v = int'($urandom_range(0, (1 << SP_W) - 1)) - (1 << (SP_W - 1));
			default:          v = corners[$urandom_range(0, 5)] + int'($urandom_range(0, 2)) - 1;
		endcase
		return SP_W'(v);
	endfunction

	function automatic logic [CYC_W-1:0] random_reg_value(input bit is_cycle);
		case ($urandom_range(0, 7))
			0:       return '1;
			1:       return '0;
			2, 3:    return is_cycle ? CYC_W'($urandom_range(0, 4200)) : CYC_W'($urandom);
			default: return CYC_W'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		int sweep [24] = '{-1024, 1023, -800, 800, -1, 0, 1, 40, 79, 80, 81, 120,
			159, 160, 161, 240, 320, 399, 400, 401, 440, 479, 480, 481};
		gaps_on = 1'b1;
		foreach (sweep[i])
			send_setpoint(SP_W'(sweep[i]));
		wait_drained();
	endtask

	task automatic test_register_extremes();
		int probes [6] = '{-5, 40, 240, 400, 440, 600};
		// heat above the cycle length: off time floors at zero
		program_registers('1, '1, '1, '1, '0);
		foreach (probes[i])
			send_setpoint(SP_W'(probes[i]));
		wait_drained();
		program_registers('0, '0, '0, '0, '1);
		foreach (probes[i])
			send_setpoint(SP_W'(probes[i]));
		wait_drained();
		program_registers(16'h0FFF, 16'hF000, 16'h0FFF, 16'hF000, 16'd1);
		foreach (probes[i])
			send_setpoint(SP_W'(probes[i]));
		wait_drained();
	endtask

	task automatic test_unused_indexes();
		for (int a = REG_CYCLE + 1; a < (1 << REG_ADDR_W); a++)
			write_reg(REG_ADDR_W'(a), CYC_W'($urandom));
		repeat (8)
			send_setpoint(random_setpoint());
		wait_drained();
	endtask

	task automatic test_backpressure();
		gaps_on = 1'b0;
		@(posedge clk);
		hold_off_left = 150;
		repeat (60)
			send_setpoint(random_setpoint());
		wait_drained();
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 5; ph++) begin
			program_registers(random_reg_value(1'b0), random_reg_value(1'b0),
				random_reg_value(1'b0), random_reg_value(1'b0), random_reg_value(1'b1));
			gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
			repeat (80)
				send_setpoint(random_setpoint());
			wait_drained();
		end
	endtask

	// receiver: long hold-offs on request, otherwise a style that changes now and then
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			heat_rsp.ready = 1'b0;
			hold_off_left--;
		end else begin
			if (rx_phase_left == 0) begin
				rx_style = rx_style_t'($urandom_range(0, 2));
				rx_phase_left = $urandom_range(16, 96);
			end
			rx_phase_left--;
			rx_tick++;
			case (rx_style)
				RX_FREE:     heat_rsp.ready = 1'b1;
				RX_RANDOM:   heat_rsp.ready = ($urandom_range(0, 99) >= 35);
				RX_PERIODIC: heat_rsp.ready = (rx_tick % 7) < 4;
				default:     heat_rsp.ready = 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		out_item_t got;
		if (arst_n && heat_rsp.valid && heat_rsp.ready) begin
			got = heat_rsp.data;
			if (pending_heat_results.size() == 0) begin
				report_mismatch("result with no request pending", got.heat_ms, 0);
			end else begin
				want = pending_heat_results.pop_front();
				if (got.mu_negative !== want.mu_negative)
					report_mismatch("mu_negative", got.mu_negative, want.mu_negative);
				if (got.mu_small !== want.mu_small)
					report_mismatch("mu_small", got.mu_small, want.mu_small);
				if (got.mu_medium !== want.mu_medium)
					report_mismatch("mu_medium", got.mu_medium, want.mu_medium);
				if (got.mu_large !== want.mu_large)
					report_mismatch("mu_large", got.mu_large, want.mu_large);
				if (got.heat_ms !== want.heat_ms)
					report_mismatch("heat_ms", got.heat_ms, want.heat_ms);
				if (got.off_ms !== want.off_ms)
					report_mismatch("off_ms", got.off_ms, want.off_ms);
				if (got.no_rule !== want.no_rule)
					report_mismatch("no_rule", got.no_rule, want.no_rule);
			end
		end
	end

	always @(posedge clk) begin
		if ((sp_req.valid && sp_req.ready) || (heat_rsp.valid && heat_rsp.ready)
				|| (reg_wr.valid && reg_wr.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		sp_req.valid = 1'b0;
		sp_req.data = '0;
		heat_rsp.ready = 1'b0;
		reg_wr.valid = 1'b0;
		reg_wr.data = '0;
		rule_ms[SET_NEG] = 12'd0;
		rule_ms[SET_SMALL] = 12'd200;
		rule_ms[SET_MED] = 12'd500;
		rule_ms[SET_LARGE] = 12'd1000;
		cycle_len = 16'd1000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_register_extremes();
		test_unused_indexes();
		test_backpressure();
		test_random_phases();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
design/fsht_pkg.sv
design/fsht_chan_if.sv
design/fsht_member.sv
design/fsht_wsum.sv
design/fsht_div.sv
design/fuzzy_setpoint_to_heat_time_core.sv
design/fsht_checker.sv
tb/fuzzy_setpoint_to_heat_time_core_tb.sv
